// File: rtl/bleenc_pkg.sv
package bleenc_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [23:0] CRC_INIT = 24'hAAAAAA;
	localparam logic [23:0] CRC_POLY = 24'hDA6000;
	localparam logic [7:0]  LFSR_TAPS = 8'h88;
	localparam logic [6:0]  LFSR_SET = 7'h40;

	localparam logic [6:0] CHAN_NUM [4] = '{7'd37, 7'd38, 7'd39, 7'd39};

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [23:0] crc;
	} entry_t;

	typedef struct packed {
		logic full;
		logic nempty;
	} qstat_t;

	typedef enum logic [1:0] {
		PH_DATA,
		PH_CRC0,
		PH_CRC1,
		PH_CRC2
	} phase_t;

	function automatic logic [6:0] lfsr_seed(input logic [1:0] chan);
		return CHAN_NUM[chan] | LFSR_SET;
	endfunction

	function automatic logic [23:0] crc_byte(input logic [23:0] r_in, input logic [7:0] d);
		logic [23:0] r;
		logic        fb;
		r = r_in;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ d[i];
			r = r >> 1;
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	// {next lfsr, whitening mask}
	function automatic logic [14:0] whiten(input logic [6:0] l_in);
		logic [7:0] l;
		logic [7:0] m;
		l = {1'b0, l_in};
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (l[0]) begin
				l = l ^ LFSR_TAPS;
				m[i] = 1'b1;
			end
			l = l >> 1;
		end
		return {l[6:0], m};
	endfunction

	function automatic logic [7:0] bit_rev(input logic [7:0] a);
		logic [7:0] v;
		for (int i = 0; i < 8; i++) begin
			v[7 - i] = a[i];
		end
		return v;
	endfunction

endpackage

// File: rtl/bleenc_front.sv
module bleenc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                is_last,
	input  bleenc_pkg::qstat_t  qstat,
	output logic                push,
	output bleenc_pkg::entry_t  push_entry
);

	logic [23:0] crc_q;
	logic [23:0] crc_next;

	assign crc_next = bleenc_pkg::crc_byte(crc_q, data_byte);
	assign in_stall = qstat.full;
	assign push = in_valid && !in_stall;

	assign push_entry.data = data_byte;
	assign push_entry.last = is_last;
	assign push_entry.crc = crc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= bleenc_pkg::CRC_INIT;
		end else if (push) begin
			crc_q <= is_last ? bleenc_pkg::CRC_INIT : crc_next;
		end
	end

endmodule

// File: rtl/bleenc_queue.sv
module bleenc_queue #(
	parameter int DEPTH = bleenc_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bleenc_pkg::entry_t  push_entry,
	input  logic                pop,
	output bleenc_pkg::entry_t  head,
	output bleenc_pkg::qstat_t  qstat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	bleenc_pkg::entry_t slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign head = slot_q[rd_ptr_q];
	assign qstat.full = (count_q == CNT_W'(DEPTH));
	assign qstat.nempty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_pop_nempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.nempty)
		else $error("pop from empty queue");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");
`endif

endmodule

// File: rtl/bleenc_back.sv
module bleenc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_data,
	input  bleenc_pkg::entry_t  head,
	input  bleenc_pkg::qstat_t  qstat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          wire_byte,
	output logic                end_of_packet
);

	bleenc_pkg::phase_t phase_q;
	bleenc_pkg::phase_t phase_d;
	logic [1:0]         chan_q;
	logic [6:0]         lfsr_q;
	logic               mid_q;
	logic               out_valid_q;
	logic [7:0]         wire_byte_q;
	logic               eop_q;
	logic               load;
	logic [7:0]         sel_byte;
	logic [14:0]        wht;

	assign cfg_ready = 1'b1;
	assign load = (!out_valid_q || !out_stall) && qstat.nempty;
	assign wht = bleenc_pkg::whiten(lfsr_q);

	always_comb begin
		sel_byte = head.data;
		phase_d = phase_q;
		pop = 1'b0;
		unique case (phase_q)
			bleenc_pkg::PH_DATA: begin
				sel_byte = head.data;
				if (load) begin
					phase_d = head.last ? bleenc_pkg::PH_CRC0 : bleenc_pkg::PH_DATA;
					pop = !head.last;
				end
			end
			bleenc_pkg::PH_CRC0: begin
				sel_byte = head.crc[7:0];
				if (load) begin
					phase_d = bleenc_pkg::PH_CRC1;
				end
			end
			bleenc_pkg::PH_CRC1: begin
				sel_byte = head.crc[15:8];
				if (load) begin
					phase_d = bleenc_pkg::PH_CRC2;
				end
			end
			bleenc_pkg::PH_CRC2: begin
				sel_byte = head.crc[23:16];
				if (load) begin
					phase_d = bleenc_pkg::PH_DATA;
					pop = 1'b1;
				end
			end
			default: begin
				phase_d = bleenc_pkg::PH_DATA;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bleenc_pkg::PH_DATA;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0;
			lfsr_q <= bleenc_pkg::lfsr_seed(2'd0);
			mid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (phase_q == bleenc_pkg::PH_CRC2) begin
					lfsr_q <= bleenc_pkg::lfsr_seed(chan_q);
					mid_q <= 1'b0;
				end else begin
					lfsr_q <= wht[14:8];
					mid_q <= 1'b1;
				end
			end else begin
				if (!out_stall) begin
					out_valid_q <= 1'b0;
				end
				if (cfg_valid && cfg_ready && !mid_q) begin
					lfsr_q <= bleenc_pkg::lfsr_seed(cfg_data);
				end
			end
			if (cfg_valid && cfg_ready) begin
				chan_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			wire_byte_q <= bleenc_pkg::bit_rev(sel_byte ^ wht[7:0]);
			eop_q <= (phase_q == bleenc_pkg::PH_CRC2);
		end
	end

	assign out_valid = out_valid_q;
	assign wire_byte = wire_byte_q;
	assign end_of_packet = eop_q;

`ifndef ASSERT_OFF
	a_tail_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != bleenc_pkg::PH_DATA) |-> qstat.nempty)
		else $error("CRC tail without queued entry");

	a_eop_ends_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && eop_q) |-> (phase_q == bleenc_pkg::PH_DATA))
		else $error("end of packet while tail still running");

	a_tail_order: assert property (@(posedge clk) disable iff (!arst_n)
		(load && phase_q == bleenc_pkg::PH_CRC2) |=> (phase_q == bleenc_pkg::PH_DATA))
		else $error("tail sequencer did not return to data");
`endif

endmodule

// File: rtl/ble_adv_crc_whiten_encoder.sv
// channel  handshake            payload
// cfg      cfg_valid/cfg_ready  cfg_data[1:0] (advertising channel index)
// in       in_valid/in_stall    data_byte[7:0], is_last
// out      out_valid/out_stall  wire_byte[7:0], end_of_packet
//
// While nothing stalls, one item per cycle; a last item adds three CRC items, so a
// packet of N items yields N+3 items; the back sequencer emits one byte a cycle.
// In to out: the accepted item is written into a queue slot, and from there loaded
// into the output register.
// Reset: CRC 0xAAAAAA, channel 37, whitening LFSR 0x65, queue empty.
// in_stall rises only when the queue is full; out_stall holds the output register.
module ble_adv_crc_whiten_encoder #(
	parameter int QUEUE_DEPTH = bleenc_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] wire_byte,
	output logic       end_of_packet
);

	bleenc_pkg::qstat_t qstat;
	bleenc_pkg::entry_t push_entry;
	bleenc_pkg::entry_t head;
	logic               push;
	logic               pop;

	bleenc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.is_last    (is_last),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	bleenc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	bleenc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.wire_byte     (wire_byte),
		.end_of_packet (end_of_packet)
	);

endmodule
